// ===== src/gn3_pkg.sv =====
// Shared types and constants for the 3D gradient noise block.
package gn3_pkg;

	localparam logic MODE_EVAL = 1'b0;
	localparam logic MODE_LOAD = 1'b1;

	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] HASH_LAST  = 5'd27;  // last step of the 14 table reads
	localparam logic [STEP_W-1:0] BLEND_LAST = 5'd13;  // last step of the 7 lerps
	localparam logic [3:0] FADE_OPS = 4'd12;           // 4 multiplies per axis

	typedef struct packed {
		logic        mode;
		logic [23:0] pos_x;
		logic [23:0] pos_y;
		logic [23:0] pos_z;
		logic [7:0]  entry_index;
		logic [7:0]  entry_value;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] noise_value;
	} out_beat_t;

	typedef struct packed {
		logic       latch;      // capture an evaluate beat
		logic       load;       // write one table entry
		logic       rd_issue;   // table read, data captured next cycle
		logic [3:0] rd_idx;
		logic       mul_issue;  // multiply, written back next cycle
		logic       mul_lerp;   // 0: fade op, 1: lerp op
		logic [3:0] mul_idx;
		logic       finish;     // load the result register
	} gn3_cmd_t;

endpackage

// ===== src/gn3_stream_if.sv =====
// Valid/ready stream interface carrying one beat of type T.
interface gn3_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== src/gn3_ctrl.sv =====
// Sequencer for the noise block: issues input capture, table writes, table reads, multiplies and output load.
module gn3_ctrl import gn3_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_mode,
	output logic     in_ready,
	input  logic     out_ready,
	output logic     out_valid,
	output gn3_cmd_t cmd
);

	typedef enum logic [1:0] {ST_IDLE, ST_HASH, ST_BLEND, ST_FINISH} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.latch = in_valid && (in_mode == MODE_EVAL);
				cmd.load  = in_valid && (in_mode == MODE_LOAD);
			end
			ST_HASH: begin
				if (!step_q[0]) begin
					cmd.rd_issue = 1'b1;
					cmd.rd_idx   = step_q[4:1];
					if (step_q[4:1] < FADE_OPS) begin
						cmd.mul_issue = 1'b1;
						cmd.mul_idx   = step_q[4:1];
					end
				end
			end
			ST_BLEND: begin
				if (!step_q[0]) begin
					cmd.mul_issue = 1'b1;
					cmd.mul_lerp  = 1'b1;
					cmd.mul_idx   = step_q[4:1];
				end
			end
			ST_FINISH: cmd.finish = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (in_valid && (in_mode == MODE_EVAL))
						state_q <= ST_HASH;
				end
				ST_HASH: begin
					if (step_q == HASH_LAST) begin
						step_q  <= '0;
						state_q <= ST_BLEND;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_BLEND: begin
					if (step_q == BLEND_LAST) begin
						step_q  <= '0;
						state_q <= ST_FINISH;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken beat");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_issue || cmd.mul_issue) |-> !in_ready)
		else $error("work issued while accepting");

	a_hash_to_blend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HASH && step_q == HASH_LAST) |=> (state_q == ST_BLEND))
		else $error("hash phase did not hand over to blend");

	a_valid_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("output valid without finish");

endmodule

// ===== src/gn3_dp.sv =====
// Datapath: permutation memory, hash registers, shared multiplier, output stage.
module gn3_dp import gn3_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int OUT_BITS  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  gn3_cmd_t  cmd,
	input  in_beat_t  in_beat,
	output out_beat_t out_beat
);

	localparam int F = FRAC_BITS;
	localparam int W = F + 5;  // signed inner width, holds up to +-15.x
	localparam logic signed [W-1:0] ONE_Q = {4'b0000, 1'b1, {F{1'b0}}};
	localparam logic signed [W-1:0] TEN_Q = (ONE_Q <<< 3) + (ONE_Q <<< 1);
	localparam logic signed [W-1:0] FIF_Q = (ONE_Q <<< 4) - ONE_Q;
	localparam logic [W+OUT_BITS-2:0] MAXV = {{(W-1){1'b0}}, {OUT_BITS{1'b1}}};

	function automatic logic signed [W-1:0] grad(input logic [3:0] h,
		input logic signed [W-1:0] x, input logic signed [W-1:0] y,
		input logic signed [W-1:0] z);
		logic signed [W-1:0] u;
		logic signed [W-1:0] v;
		u = h[3] ? y : x;
		if (h < 4'd4)
			v = y;
		else if (h == 4'd12 || h == 4'd14)
			v = x;
		else
			v = z;
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

	// permutation table
	logic [7:0] perm_mem [256];
	logic [7:0] rd_q;
	logic [7:0] rd_addr;

	// evaluate point
	logic [7:0]   xi_q, yi_q, zi_q;
	logic [F-1:0] xf_q, yf_q, zf_q;

	// hash chain
	logic [7:0] hx_q [2];
	logic [7:0] hb_q [4];
	logic [7:0] hh_q [8];

	logic       rd_pend_q;
	logic [3:0] rd_idx_s1;

	// arithmetic
	logic signed [W-1:0] inner_q, f2_q, f3_q;
	logic signed [W-1:0] fade_q [3];
	logic signed [W-1:0] lr_q [7];

	logic signed [W-1:0]   mul_a, mul_b, mul_add;
	logic signed [2*W-1:0] mul_p;
	logic signed [2*W-1:0] prod_s1;
	logic signed [W-1:0]   add_s1;
	logic                  mul_pend_q;
	logic                  lerp_s1;
	logic [3:0]            idx_s1;
	logic signed [W-1:0]   mul_res;

	logic signed [W-1:0] xfw, yfw, zfw, f_sel;
	logic signed [W-1:0] g [8];

	logic [7:0] yi1, zi1;
	logic [1:0] rj;
	logic [2:0] rc, cc;

	// output stage
	logic signed [W-1:0]    s_val;
	logic [W-2:0]           s_pos;
	logic [W+OUT_BITS-2:0]  r_w;
	logic [OUT_BITS-1:0]    r_sat;

	assign yi1 = yi_q + 8'd1;
	assign zi1 = zi_q + 8'd1;
	assign xfw = W'(xf_q);
	assign yfw = W'(yf_q);
	assign zfw = W'(zf_q);

	// read address
	assign rj = 2'(cmd.rd_idx - 4'd2);
	assign rc = 3'(cmd.rd_idx - 4'd6);
	always_comb begin
		priority if (cmd.rd_idx == 4'd0)
			rd_addr = xi_q;
		else if (cmd.rd_idx == 4'd1)
			rd_addr = xi_q + 8'd1;
		else if (cmd.rd_idx < 4'd6)
			rd_addr = hx_q[rj[0]] + (rj[1] ? yi1 : yi_q);
		else
			rd_addr = hb_q[rc[1:0]] + (rc[2] ? zi1 : zi_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			perm_mem[in_beat.entry_index] <= in_beat.entry_value;
		if (cmd.rd_issue)
			rd_q <= perm_mem[rd_addr];
	end

	// corner gradients, corner c = {zs,ys,xs}
	always_comb begin
		for (int c = 0; c < 8; c++) begin
			g[c] = grad(hh_q[c][3:0],
				c[0] ? xfw - ONE_Q : xfw,
				c[1] ? yfw - ONE_Q : yfw,
				c[2] ? zfw - ONE_Q : zfw);
		end
	end

	always_comb begin
		unique case (cmd.mul_idx[3:2])
			2'd0:    f_sel = xfw;
			2'd1:    f_sel = yfw;
			default: f_sel = zfw;
		endcase
	end

	// operand select: result = floor(a*b / ONE) + add
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_add = '0;
		if (!cmd.mul_lerp) begin
			unique case (cmd.mul_idx[1:0])
				2'd0: begin
					mul_a   = f_sel;
					mul_b   = (f_sel <<< 2) + (f_sel <<< 1) - FIF_Q;
					mul_add = TEN_Q;
				end
				2'd1: begin
					mul_a = f_sel;
					mul_b = f_sel;
				end
				2'd2: begin
					mul_a = f2_q;
					mul_b = f_sel;
				end
				default: begin
					mul_a = f3_q;
					mul_b = inner_q;
				end
			endcase
		end else begin
			unique case (cmd.mul_idx[2:0])
				3'd0, 3'd1, 3'd2, 3'd3: begin
					mul_a   = fade_q[0];
					mul_b   = g[{cmd.mul_idx[1:0], 1'b1}] - g[{cmd.mul_idx[1:0], 1'b0}];
					mul_add = g[{cmd.mul_idx[1:0], 1'b0}];
				end
				3'd4: begin
					mul_a   = fade_q[1];
					mul_b   = lr_q[1] - lr_q[0];
					mul_add = lr_q[0];
				end
				3'd5: begin
					mul_a   = fade_q[1];
					mul_b   = lr_q[3] - lr_q[2];
					mul_add = lr_q[2];
				end
				3'd6: begin
					mul_a   = fade_q[2];
					mul_b   = lr_q[5] - lr_q[4];
					mul_add = lr_q[4];
				end
				default: ;
			endcase
		end
	end

	assign mul_p   = mul_a * mul_b;
	assign mul_res = W'(prod_s1 >>> F) + add_s1;

	// corner slot of the read now returning
	assign cc = 3'(rd_idx_s1 - 4'd6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q  <= 1'b0;
			mul_pend_q <= 1'b0;
		end else begin
			rd_pend_q  <= cmd.rd_issue;
			mul_pend_q <= cmd.mul_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			xi_q <= 8'(in_beat.pos_x >> F);
			yi_q <= 8'(in_beat.pos_y >> F);
			zi_q <= 8'(in_beat.pos_z >> F);
			xf_q <= F'(in_beat.pos_x);
			yf_q <= F'(in_beat.pos_y);
			zf_q <= F'(in_beat.pos_z);
		end
		if (cmd.rd_issue)
			rd_idx_s1 <= cmd.rd_idx;
		if (rd_pend_q) begin
			priority if (rd_idx_s1 < 4'd2)
				hx_q[rd_idx_s1[0]] <= rd_q;
			else if (rd_idx_s1 < 4'd6)
				hb_q[2'(rd_idx_s1 - 4'd2)] <= rd_q;
			else
				hh_q[cc] <= rd_q;
		end
		if (cmd.mul_issue) begin
			prod_s1 <= mul_p;
			add_s1  <= mul_add;
			lerp_s1 <= cmd.mul_lerp;
			idx_s1  <= cmd.mul_idx;
		end
		if (mul_pend_q) begin
			if (lerp_s1) begin
				if (idx_s1[2:0] != 3'd7)
					lr_q[idx_s1[2:0]] <= mul_res;
			end else begin
				unique case (idx_s1[1:0])
					2'd0: inner_q <= mul_res;
					2'd1: f2_q    <= mul_res;
					2'd2: f3_q    <= mul_res;
					default: begin
						if (idx_s1[3:2] != 2'd3)
							fade_q[idx_s1[3:2]] <= mul_res;
					end
				endcase
			end
		end
		if (cmd.finish)
			out_beat.noise_value <= 16'(r_sat);
	end

	// map n in [-1,1] to [0,1], scale to OUT_BITS and saturate
	assign s_val = lr_q[6] + ONE_Q;
	assign s_pos = s_val[W-1] ? '0 : s_val[W-2:0];
	assign r_w   = ((W+OUT_BITS-1)'(s_pos) << OUT_BITS) >> (F + 1);
	assign r_sat = (r_w > MAXV) ? '1 : OUT_BITS'(r_w);

endmodule

// ===== src/gradient_noise_3d.sv =====
// An evaluate beat (mode 0) is captured at its accept edge. Its result takes
// fourteen dependent reads of the permutation table through its single
// registered read port (the later addresses built from earlier reads), then
// the seven trilinear blend multiplies on the shared two-stage multiplier,
// and a final step that maps the noise to [0,1], saturates it and loads the
// output register. The twelve fade multiplies run on the same multiplier
// during the table reads. The input is ready again in the cycle the result
// turns valid; the final step stalls while an earlier result is still
// untaken. A load beat (mode 1) writes one table entry in its accept cycle
// and gives no result; the next beat may follow at once. One point is in
// flight at a time; a finished result waits in the output register while
// the next beat is taken.
// Every table entry that a point uses must have been loaded first.
module gradient_noise_3d import gn3_pkg::*; #(
	parameter int FRAC_BITS = 16,  // fraction bits of the positions, 8 to 24
	parameter int OUT_BITS  = 16   // result fraction bits, 8 to 16
) (
	input  logic         clk,
	input  logic         arst_n,
	gn3_stream_if.sink   req,
	gn3_stream_if.source rsp
);

	gn3_cmd_t  cmd;
	out_beat_t res;

	// controller: sequencing of reads, multiplies and output handshake
	gn3_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_mode   (req.data.mode),
		.in_ready  (req.ready),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.cmd       (cmd)
	);

	// datapath: table memory, hash chain, fade and blend arithmetic
	gn3_dp #(
		.FRAC_BITS (FRAC_BITS),
		.OUT_BITS  (OUT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_beat  (req.data),
		.out_beat (res)
	);

	assign rsp.data = res;

endmodule

// ===== test/gn3_noise_checker.sv =====
// Checker for gradient_noise_3d: computes noise values from the accepted beats and compares them.
module gn3_noise_checker import gn3_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_ready,
	input  in_beat_t   req_data,
	input  logic       rsp_valid,
	input  logic       rsp_ready,
	input  out_beat_t  rsp_data,
	output int         fail_count,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 16;
	localparam int OB = 16;
	localparam longint ONE = 64'sd1 <<< FB;

	logic [7:0] perm [256];
	logic [15:0] noise_q [$];

	function automatic longint fx_mul(longint a, longint b);
		longint p;
		p = a * b;
		return p >>> FB;  // arithmetic shift floors toward minus infinity
	endfunction

	function automatic longint fade(longint f);
		longint inner, f2, f3;
		inner = fx_mul(f, 6 * f - 15 * ONE) + 10 * ONE;
		f2 = fx_mul(f, f);
		f3 = fx_mul(f2, f);
		return fx_mul(f3, inner);
	endfunction

	function automatic longint mix(longint a, longint b, longint t);
		return a + fx_mul(t, b - a);
	endfunction

	function automatic longint grad(logic [7:0] hash, longint x, longint y, longint z);
		logic [3:0] h;
		longint u, v;
		h = hash[3:0];
		u = (h < 8) ? x : y;
		if (h < 4) v = y;
		else if (h == 12 || h == 14) v = x;
		else v = z;
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

	function automatic logic [7:0] hash3(logic [7:0] x, logic [7:0] y, logic [7:0] z);
		logic [7:0] a, b;
		a = perm[x];
		b = perm[8'(a + y)];
		return perm[8'(b + z)];
	endfunction

	function automatic logic [15:0] noise_at(logic [23:0] px, logic [23:0] py, logic [23:0] pz);
		logic [7:0] xi, yi, zi, x1, y1, z1;
		longint xf, yf, zf, xm, ym, zm, u, v, w, a1, a2, b1, b2, n, s, r;
		xi = px[23:16]; yi = py[23:16]; zi = pz[23:16];
		x1 = xi + 8'd1; y1 = yi + 8'd1; z1 = zi + 8'd1;
		xf = longint'(px[15:0]); yf = longint'(py[15:0]); zf = longint'(pz[15:0]);
		xm = xf - ONE; ym = yf - ONE; zm = zf - ONE;
		u = fade(xf); v = fade(yf); w = fade(zf);
		a1 = mix(grad(hash3(xi, yi, zi), xf, yf, zf), grad(hash3(x1, yi, zi), xm, yf, zf), u);
		a2 = mix(grad(hash3(xi, y1, zi), xf, ym, zf), grad(hash3(x1, y1, zi), xm, ym, zf), u);
		b1 = mix(grad(hash3(xi, yi, z1), xf, yf, zm), grad(hash3(x1, yi, z1), xm, yf, zm), u);
		b2 = mix(grad(hash3(xi, y1, z1), xf, ym, zm), grad(hash3(x1, y1, z1), xm, ym, zm), u);
		n = mix(mix(a1, a2, v), mix(b1, b2, v), w);
		s = n + ONE;
		if (s < 0) s = 0;
		r = (s <<< OB) >>> (FB + 1);
		if (r > 65535) r = 65535;
		return r[15:0];
	endfunction

	assign pending = noise_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (req_valid && req_ready) begin
				if (req_data.mode == MODE_LOAD)
					perm[req_data.entry_index] = req_data.entry_value;
				else
					noise_q.push_back(noise_at(req_data.pos_x, req_data.pos_y, req_data.pos_z));
			end
			if (rsp_valid && rsp_ready) begin
				if (noise_q.size() == 0) begin
					$error("noise_value: unexpected beat, actual %0d", rsp_data.noise_value);
					fail_count <= fail_count + 1;
				end else begin
					if (noise_q[0] !== rsp_data.noise_value) begin
						$error("noise_value: expected %0d actual %0d", noise_q[0],
							rsp_data.noise_value);
						fail_count <= fail_count + 1;
					end
					void'(noise_q.pop_front());
				end
			end
		end
	end
endmodule

// ===== test/gradient_noise_3d_tb.sv =====
// Top-level testbench for gradient_noise_3d: stimulus, stalls and verdict.
module gradient_noise_3d_tb;
	import gn3_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int   fail_count, pending;
	int   cycle_count;
	bit   no_gaps;   // set during a stretch with no idling on either side

	gn3_stream_if #(.T(in_beat_t))  req ();
	gn3_stream_if #(.T(out_beat_t)) rsp ();

	gradient_noise_3d u_dut (.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source));

	gn3_noise_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result side: ready drops with a chance of about 19 in a hundred, except in the calm stretch.
	initial rsp.ready = 1'b0;
	always @(posedge clk) begin
		rsp.ready <= no_gaps || ($urandom_range(99) >= 19);
	end

	// Watchdog: about 2000 beats, under 900 of them points, with their stalls,
	// fit well under this limit.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 1000000) begin
			$display("gradient_noise_3d verification failed");
			$finish;
		end
	end

	// Hand one beat over: hold valid until accepted, idling randomly beforehand.
	task automatic send(in_beat_t b);
		while (!no_gaps && $urandom_range(99) < 19) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= b;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic load_entry(logic [7:0] idx, logic [7:0] val);
		in_beat_t b;
		b = '0;
		b.mode = MODE_LOAD;
		b.entry_index = idx;
		b.entry_value = val;
		b.pos_x = 24'($urandom); b.pos_y = 24'($urandom); b.pos_z = 24'($urandom);  // ignored
		send(b);
	endtask

	task automatic eval_point(logic [23:0] x, logic [23:0] y, logic [23:0] z);
		in_beat_t b;
		b.mode = MODE_EVAL;
		b.pos_x = x; b.pos_y = y; b.pos_z = z;
		b.entry_index = 8'($urandom); b.entry_value = 8'($urandom);  // ignored
		send(b);
	endtask

	// Full table fill: a random shuffle, the identity, or a constant pattern for the extremes.
	task automatic fill_table(int kind);
		logic [7:0] p [256];
		logic [7:0] t;
		int j;
		for (int i = 0; i < 256; i++) p[i] = (kind == 1) ? 8'hFF : (kind == 2) ? 8'h00 : 8'(i);
		if (kind == 0)
			for (int i = 255; i > 0; i--) begin
				j = $urandom_range(i);
				t = p[i]; p[i] = p[j]; p[j] = t;
			end
		for (int i = 0; i < 256; i++) load_entry(8'(i), p[i]);
	endtask

	task automatic rand_point();
		int k;
		k = $urandom_range(9);
		// mostly arbitrary, sometimes on lattice points or at fraction extremes
		if (k < 7) eval_point(24'($urandom), 24'($urandom), 24'($urandom));
		else if (k < 9) eval_point({8'($urandom), 16'h0}, {8'($urandom), 16'hFFFF},
			{8'($urandom), 16'($urandom_range(1) ? 16'h8000 : 16'h0001)});
		else eval_point(24'hFFFFFF, {8'($urandom), 16'h0}, 24'hFFFFFF);
	endtask

	initial begin
		arst_n    = 1'b0;
		no_gaps   = 1'b0;
		req.valid = 1'b0;
		req.data  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: constant tables exercise gradient codes 15 and 0.
		fill_table(1);
		eval_point(24'h000000, 24'h000000, 24'h000000);
		eval_point(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		eval_point(24'h008000, 24'h008000, 24'h008000);
		fill_table(2);
		eval_point(24'hFFFFFF, 24'h000000, 24'hFFFFFF);
		eval_point(24'h00FFFF, 24'h010000, 24'h7F8000);
		// Identity then each low nibble code at one corner.
		fill_table(3);
		for (int h = 0; h < 16; h++) begin
			load_entry(8'd0, 8'(h));
			eval_point(24'h004000, 24'h00C000, 24'h002000);
		end

		// Random: a shuffled table, repeated single-entry rewrites, many points.
		fill_table(0);
		for (int i = 0; i < 940; i++) begin
			if (i == 300) no_gaps = 1'b1;
			if (i == 500) no_gaps = 1'b0;
			if ($urandom_range(99) < 8) load_entry(8'($urandom), 8'($urandom));
			else rand_point();
		end
		req.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("gradient_noise_3d verification clean");
		else
			$display("gradient_noise_3d verification failed");
		$finish;
	end
endmodule

// ===== gradient_noise_3d.f =====
src/gn3_pkg.sv
src/gn3_stream_if.sv
src/gn3_ctrl.sv
src/gn3_dp.sv
src/gradient_noise_3d.sv
test/gn3_noise_checker.sv
test/gradient_noise_3d_tb.sv
